/* hw/rtl/atfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfm_pkg - shared types and constants for the amplifier thermal/fault monitor
// Item and result structs, state record, command and mode codes, tier tables.
// ----------------------------------------------------------------------------
package atfm_pkg;

	// Timer periods, in millisecond ticks
	localparam logic [7:0] THERMAL_PERIOD = 8'd250;
	localparam logic [7:0] FAULT_PERIOD   = 8'd200;
	localparam logic [9:0] SECOND_TICKS   = 10'd1000;

	// Command codes
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_AMP_ON  = 2'd1;
	localparam logic [1:0] FUNC_AMP_OFF = 2'd2;
	localparam logic [1:0] FUNC_LED     = 2'd3;

	// LED modes
	localparam logic [2:0] LED_OFF        = 3'd0;
	localparam logic [2:0] LED_ON         = 3'd1;
	localparam logic [2:0] LED_SLOW       = 3'd2;
	localparam logic [2:0] LED_FAST       = 3'd3;
	localparam logic [2:0] LED_LONG_BLINK = 3'd4;

	localparam logic [9:0] LED_SLOW_TICKS = 10'd500;
	localparam logic [9:0] LED_FAST_TICKS = 10'd100;
	localparam logic [9:0] LED_LONG_TICKS = 10'd1000;
	localparam logic [9:0] LED_ELAPSED_MAX = 10'd1023;

	// Governor tiers
	localparam logic [1:0] TIER_NORMAL   = 2'd0;
	localparam logic [1:0] TIER_WARM     = 2'd1;
	localparam logic [1:0] TIER_THROTTLE = 2'd2;
	localparam logic [1:0] TIER_CRITICAL = 2'd3;

	// Temperature handling, Q8.4
	localparam logic [11:0] TEMP_VALID_LIMIT = 12'd2080;  // 130 degC
	localparam logic [12:0] WARM_MARGIN      = 13'd160;   // 10 degC
	localparam logic [21:0] FILT_OLD_WEIGHT  = 22'd870;
	localparam logic [21:0] FILT_NEW_WEIGHT  = 22'd154;
	localparam logic [21:0] FILT_ROUND       = 22'd512;

	localparam logic [15:0] FAULT_COUNT_MAX = 16'hFFFF;

	// Configuration register indexes
	localparam logic [1:0] CFG_GOV_ENABLE   = 2'd0;
	localparam logic [1:0] CFG_THROTTLE     = 2'd1;
	localparam logic [1:0] CFG_CRITICAL     = 2'd2;

	localparam logic        GOV_ENABLE_RST  = 1'b1;
	localparam logic [11:0] THROTTLE_RST    = 12'd1200;
	localparam logic [11:0] CRITICAL_RST    = 12'd1360;

	typedef struct packed {
		logic [1:0]  func;
		logic [11:0] temp_sample;
		logic        fault_pin;
		logic [2:0]  led_mode_req;
	} item_t;

	typedef struct packed {
		logic               amp_enabled;
		logic               fault_flag;
		logic [15:0]        fault_total;
		logic               led_level;
		logic [2:0]         led_mode_now;
		logic [1:0]         governor_tier;
		logic [15:0]        gain_q15;
		logic signed [3:0]  attenuation_db;
		logic               governor_active;
		logic [11:0]        temp_average;
		logic [31:0]        uptime_seconds;
	} result_t;

	typedef struct packed {
		logic        governor_enable;
		logic [11:0] throttle_temp;
		logic [11:0] critical_temp;
	} cfg_t;

	typedef struct packed {
		logic [11:0] filtered_temp;
		logic        temp_loaded;
		logic [1:0]  tier;
		logic        active;
		logic        amp_on;
		logic        fault_seen;
		logic [15:0] fault_counter;
		logic [2:0]  led_mode;
		logic        led_toggle;
		logic        led_pin;
		logic [9:0]  led_elapsed;
		logic [7:0]  thermal_elapsed;
		logic [7:0]  fault_elapsed;
		logic [9:0]  ms_elapsed;
		logic [31:0] seconds_count;
	} state_t;

	function automatic logic [15:0] tier_gain(input logic [1:0] tier);
		logic [15:0] g;
		case (tier)
			TIER_NORMAL:   g = 16'd32768;
			TIER_WARM:     g = 16'd29196;
			TIER_THROTTLE: g = 16'd23200;
			TIER_CRITICAL: g = 16'd16417;
			default:       g = 16'd32768;
		endcase
		return g;
	endfunction

	function automatic logic signed [3:0] tier_atten(input logic [1:0] tier);
		logic signed [3:0] a;
		case (tier)
			TIER_NORMAL:   a = 4'sd0;
			TIER_WARM:     a = -4'sd1;
			TIER_THROTTLE: a = -4'sd3;
			TIER_CRITICAL: a = -4'sd6;
			default:       a = 4'sd0;
		endcase
		return a;
	endfunction

	function automatic logic [9:0] led_interval(input logic [2:0] mode);
		logic [9:0] n;
		case (mode)
			LED_FAST:       n = LED_FAST_TICKS;
			LED_LONG_BLINK: n = LED_LONG_TICKS;
			default:        n = LED_SLOW_TICKS;
		endcase
		return n;
	endfunction

endpackage

/* hw/rtl/atfm_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atfm_update - next-state and result logic for one command
// Tick handling (LED, uptime, thermal governor, fault poll) and the commands.
// ----------------------------------------------------------------------------
module atfm_update (
	input  atfm_pkg::state_t  st,
	input  atfm_pkg::cfg_t    cfg,
	input  atfm_pkg::item_t   item,
	output atfm_pkg::state_t  st_next,
	output atfm_pkg::result_t result
);

	logic        sample_ok;
	logic [21:0] filt_acc;
	logic [9:0]  interval;

	assign sample_ok = (item.temp_sample != 12'd0) &&
		(item.temp_sample < atfm_pkg::TEMP_VALID_LIMIT);

	assign filt_acc = atfm_pkg::FILT_OLD_WEIGHT * {10'd0, st.filtered_temp}
		+ atfm_pkg::FILT_NEW_WEIGHT * {10'd0, item.temp_sample}
		+ atfm_pkg::FILT_ROUND;

	assign interval = atfm_pkg::led_interval(st.led_mode);

	always_comb begin
		st_next = st;
		case (item.func)
			atfm_pkg::FUNC_TICK: begin
				// LED first, on the mode held before this tick
				if (st.led_elapsed != atfm_pkg::LED_ELAPSED_MAX)
					st_next.led_elapsed = st.led_elapsed + 10'd1;
				if (st.led_mode == atfm_pkg::LED_OFF) begin
					st_next.led_pin = 1'b0;
				end else if (st.led_mode == atfm_pkg::LED_ON) begin
					st_next.led_pin = 1'b1;
				end else if (st_next.led_elapsed >= interval) begin
					st_next.led_elapsed = 10'd0;
					st_next.led_toggle = ~st.led_toggle;
					st_next.led_pin = ~st.led_toggle;
				end

				if (st.ms_elapsed >= atfm_pkg::SECOND_TICKS - 10'd1) begin
					st_next.ms_elapsed = 10'd0;
					st_next.seconds_count = st.seconds_count + 32'd1;
				end else begin
					st_next.ms_elapsed = st.ms_elapsed + 10'd1;
				end

				if (st.thermal_elapsed >= atfm_pkg::THERMAL_PERIOD - 8'd1) begin
					st_next.thermal_elapsed = 8'd0;
					if (sample_ok) begin
						st_next.temp_loaded = 1'b1;
						st_next.filtered_temp = st.temp_loaded ? filt_acc[21:10]
							: item.temp_sample;
					end
					st_next.active = cfg.governor_enable;
					if (!cfg.governor_enable) begin
						st_next.tier = atfm_pkg::TIER_NORMAL;
					end else if (st_next.filtered_temp >= cfg.critical_temp) begin
						st_next.tier = atfm_pkg::TIER_CRITICAL;
						st_next.led_mode = atfm_pkg::LED_FAST;
					end else if (st_next.filtered_temp >= cfg.throttle_temp) begin
						st_next.tier = atfm_pkg::TIER_THROTTLE;
					// avg >= throttle - 160, tested as avg + 160 >= throttle so it cannot go negative
					end else if ({1'b0, st_next.filtered_temp} + atfm_pkg::WARM_MARGIN
						>= {1'b0, cfg.throttle_temp}) begin
						st_next.tier = atfm_pkg::TIER_WARM;
					end else begin
						st_next.tier = atfm_pkg::TIER_NORMAL;
					end
				end else begin
					st_next.thermal_elapsed = st.thermal_elapsed + 8'd1;
				end

				if (st.fault_elapsed >= atfm_pkg::FAULT_PERIOD - 8'd1) begin
					st_next.fault_elapsed = 8'd0;
					if (!item.fault_pin) begin
						if (!st.fault_seen) begin
							st_next.fault_seen = 1'b1;
							if (st.fault_counter != atfm_pkg::FAULT_COUNT_MAX)
								st_next.fault_counter = st.fault_counter + 16'd1;
							st_next.amp_on = 1'b0;
							st_next.led_mode = atfm_pkg::LED_FAST;
						end
					end else if (st.fault_seen) begin
						st_next.fault_seen = 1'b0;
						st_next.amp_on = 1'b1;
						st_next.led_mode = atfm_pkg::LED_ON;
					end
				end else begin
					st_next.fault_elapsed = st.fault_elapsed + 8'd1;
				end
			end
			atfm_pkg::FUNC_AMP_ON: begin
				if (!item.fault_pin) begin
					st_next.fault_seen = 1'b1;
					st_next.led_mode = atfm_pkg::LED_FAST;
				end else begin
					st_next.amp_on = 1'b1;
					st_next.fault_seen = 1'b0;
				end
			end
			atfm_pkg::FUNC_AMP_OFF: begin
				st_next.amp_on = 1'b0;
			end
			atfm_pkg::FUNC_LED: begin
				if (item.led_mode_req <= atfm_pkg::LED_LONG_BLINK)
					st_next.led_mode = item.led_mode_req;
			end
			default: begin
				st_next = st;
			end
		endcase
	end

	always_comb begin
		result.amp_enabled     = st_next.amp_on;
		result.fault_flag      = st_next.fault_seen;
		result.fault_total     = st_next.fault_counter;
		result.led_level       = st_next.led_pin;
		result.led_mode_now    = st_next.led_mode;
		result.governor_tier   = st_next.tier;
		result.gain_q15        = atfm_pkg::tier_gain(st_next.tier);
		result.attenuation_db  = atfm_pkg::tier_atten(st_next.tier);
		result.governor_active = st_next.active;
		result.temp_average    = st_next.filtered_temp;
		result.uptime_seconds  = st_next.seconds_count;
	end

endmodule

/* hw/rtl/amp_thermal_fault_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amp_thermal_fault_monitor - amplifier thermal governor and fault monitor
// Millisecond ticks drive LED blink, uptime, temperature averaging with tiered
// gain reduction, and fault-line polling; commands control amp and LED.
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  item      item_valid, item_stall, item          in  (stall driven out)
//  result    result_valid, result_stall, result    out (stall driven in)
//  cfg       cfg_valid, cfg_ready, cfg_index/data  in  (ready always high)
//
// One item per cycle while item_stall is low. An item is held in the input register, where the
// state update and result are computed; the result is then registered in the output
// register, from which it transfers. Result stall holds the output register and backs
// up into item_stall only when the output is full. Reset clears all state and loads
// the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module amp_thermal_fault_monitor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  atfm_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output atfm_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data
);

	logic               valid_s1;
	atfm_pkg::item_t    item_s1;
	atfm_pkg::state_t   state_q;
	atfm_pkg::state_t   state_next;
	atfm_pkg::cfg_t     cfg_q;
	atfm_pkg::result_t  result_next;
	atfm_pkg::result_t  result_q;
	logic               result_valid_q;
	logic               advance;

	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.governor_enable <= atfm_pkg::GOV_ENABLE_RST;
			cfg_q.throttle_temp   <= atfm_pkg::THROTTLE_RST;
			cfg_q.critical_temp   <= atfm_pkg::CRITICAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				atfm_pkg::CFG_GOV_ENABLE: cfg_q.governor_enable <= cfg_data[0];
				atfm_pkg::CFG_THROTTLE:   cfg_q.throttle_temp   <= cfg_data;
				atfm_pkg::CFG_CRITICAL:   cfg_q.critical_temp   <= cfg_data;
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	atfm_update u_update (
		.st      (state_q),
		.cfg     (cfg_q),
		.item    (item_s1),
		.st_next (state_next),
		.result  (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1)
				state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			result_q <= result_next;
	end

endmodule
